// ===== design/mdkt_pkg.sv =====
package mdkt_pkg;

   localparam int DEF_ENTRIES = 1024;
   localparam int KEY_W       = 64;
   localparam int MOVES_W     = 8;
   localparam int REQ_W       = 2;
   localparam int COUNT_W     = 11;
   localparam int RSP_W       = 24;
   localparam int REQ_DATA_W  = 72;
   localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

   localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_SET,
      OP_GET,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [MOVES_W-1:0] moves;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

endpackage

// ===== design/min_distance_key_table.sv =====
// Associative table mapping a 64-bit key to the smallest move count seen for it.
// Requests arrive as beats on the req_ channel: tuser carries the request kind
// (set minimum, get, clear) and tdata the key and offered move count. Every
// request gives exactly one response beat on the rsp_ channel with the written
// flag, the count found, the number of keys held, the full flag and the
// dropped-key flag. A two-beat queue sits between the request decoder and the
// lookup engine, so requests keep being taken while a response is stalled.
// A set or get scans the held keys one per cycle through a single memory read
// port and stops at the first matching key or after the last key held. The
// engine takes the next request only after it has answered the last one.
// The capacity register is written through csr_wen and csr_wdata; the user must
// do so only while idle, which the block itself does not enforce. It only sets
// the full flag. Reset empties the table at once and sets the capacity to 1024.
// When rsp_tready is low the response beat holds, the engine waits with its
// next result, and the queue fills before req_tready drops.
module min_distance_key_table #(
   parameter int ENTRIES = mdkt_pkg::DEF_ENTRIES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // key [63:0], moves [71:64]
   input  logic [mdkt_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [1:0]
   input  logic [mdkt_pkg::REQ_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // written [0], moves_found [8:1], item_count [19:9], full_res [20], no_room [21]
   output logic [mdkt_pkg::RSP_W-1:0] rsp_tdata,
   input  logic csr_wen,
   input  logic [mdkt_pkg::COUNT_W-1:0] csr_wdata
);
   import mdkt_pkg::*;

   logic [COUNT_W-1:0] capacity_ff, capacity_in;
   logic               cmd_vld;
   logic               cmd_pop;
   cmd_type            cmd;

   assign capacity_in = csr_wen ? csr_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   mdkt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_vld    (cmd_vld),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   mdkt_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_vld    (cmd_vld),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .capacity   (capacity_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/mdkt_front.sv =====
module mdkt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [mdkt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [mdkt_pkg::REQ_W-1:0] req_tuser,
   output logic                      cmd_vld,
   output mdkt_pkg::cmd_type         cmd,
   input  logic                      cmd_pop
);
   import mdkt_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   always_comb begin
      case (req_tuser)
         REQ_SET:   cmd_in.op = OP_SET;
         REQ_GET:   cmd_in.op = OP_GET;
         REQ_CLEAR: cmd_in.op = OP_CLEAR;
         default:   cmd_in.op = OP_NONE;
      endcase
      cmd_in.key   = req_tdata[KEY_W-1:0];
      cmd_in.moves = req_tdata[KEY_W +: MOVES_W];
   end

   assign req_tready = (count_ff != 2'd2);
   assign cmd_vld    = (count_ff != 2'd0);
   assign cmd        = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_pop && cmd_vld;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== design/mdkt_back.sv =====
module mdkt_back #(
   parameter int ENTRIES = mdkt_pkg::DEF_ENTRIES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_vld,
   input  mdkt_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   input  logic [mdkt_pkg::COUNT_W-1:0] capacity,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mdkt_pkg::RSP_W-1:0]  rsp_tdata
);
   import mdkt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [KEY_W-1:0]   key_mem [ENTRIES];
   logic [MOVES_W-1:0] cnt_mem [ENTRIES];

   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   issue_ff, issue_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [MOVES_W-1:0] rd_cnt_ff;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [MOVES_W-1:0] fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]   items_ff, items_in;
   logic               out_vld_ff, out_vld_in;
   logic [RSP_W-1:0]   out_data_ff, out_data_in;

   logic               match, last, needs_search, out_free, finish;
   logic               wr_en, wr_go, written, no_room;
   logic [IDX_W-1:0]   wr_addr;
   logic [MOVES_W-1:0] found;
   logic [CNT_W-1:0]   items_next;
   logic               full;

   assign match        = (rd_key_ff == cmd_ff.key);
   assign last         = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == items_ff);
   assign needs_search = ((cmd.op == OP_SET) || (cmd.op == OP_GET)) && (items_ff != '0);
   assign out_free     = !out_vld_ff || rsp_tready;
   assign finish       = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_vld) begin
               state_in = needs_search ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (match || last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      written    = 1'b0;
      no_room    = 1'b0;
      found      = '0;
      items_next = items_ff;
      case (cmd_ff.op)
         OP_SET: begin
            if (hit_ff) begin
               if (fcnt_ff > cmd_ff.moves) begin
                  wr_en   = 1'b1;
                  written = 1'b1;
               end
            end else if (items_ff < CNT_W'(ENTRIES)) begin
               wr_en      = 1'b1;
               wr_addr    = items_ff[IDX_W-1:0];
               written    = 1'b1;
               items_next = items_ff + CNT_W'(1);
            end else begin
               no_room = 1'b1;
            end
         end
         OP_GET:   found = hit_ff ? fcnt_ff : '0;
         OP_CLEAR: items_next = '0;
         default:  items_next = items_ff;
      endcase
      full  = (CMP_W'(items_next) == CMP_W'(capacity));
      wr_go = finish && wr_en;
   end

   always_comb begin
      cmd_pop     = (state_ff == ST_IDLE);
      issue_in    = '0;
      hit_in      = hit_ff;
      pos_in      = pos_ff;
      fcnt_in     = fcnt_ff;
      items_in    = items_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_data_in = out_data_ff;
      case (state_ff)
         ST_IDLE: begin
            hit_in = 1'b0;
            if (cmd_vld && needs_search) begin
               issue_in = IDX_W'(1);
            end
         end
         ST_SEARCH: begin
            issue_in = issue_ff + IDX_W'(1);
            if (match) begin
               hit_in  = 1'b1;
               pos_in  = rd_idx_ff;
               fcnt_in = rd_cnt_ff;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               items_in    = items_next;
               out_vld_in  = 1'b1;
               out_data_in = {2'b00, no_room, full, COUNT_W'(items_next), found, written};
            end
         end
         default: issue_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         items_ff   <= '0;
         out_vld_ff <= 1'b0;
         issue_ff   <= '0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         items_ff   <= items_in;
         out_vld_ff <= out_vld_in;
         issue_ff   <= issue_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      fcnt_ff     <= fcnt_in;
      out_data_ff <= out_data_in;
      rd_idx_ff   <= issue_ff;
      if (cmd_pop && cmd_vld) begin
         cmd_ff <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[issue_ff];
      rd_cnt_ff <= cnt_mem[issue_ff];
      if (wr_go) begin
         key_mem[wr_addr] <= cmd_ff.key;
         cnt_mem[wr_addr] <= cmd_ff.moves;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   a_items_bound: assert property (@(posedge clock) disable iff (reset)
      items_ff <= CNT_W'(ENTRIES))
      else $error("item count exceeds the entry count");

   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (CNT_W'(rd_idx_ff) < items_ff))
      else $error("search reads an entry that is not held");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && cmd_vld) |=> (state_ff != ST_IDLE))
      else $error("accepted command did not start");

endmodule
